@@ design/fbpa_pkg.sv @@
// Shared types, codes and color helpers for the framebuffer pixel access engine.
// No dependencies; every other design file except fbpa_ram imports this package.
package fbpa_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_XOR   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_FILL  = 2'd3
  } func_e;

  localparam logic [2:0] FMT_4BPP  = 3'd0;
  localparam logic [2:0] FMT_8BPP  = 3'd1;
  localparam logic [2:0] FMT_16BPP = 3'd2;
  localparam logic [2:0] FMT_24BPP = 3'd3;
  localparam logic [2:0] FMT_32BPP = 3'd4;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd3;

  // Widest byte address the front end produces: 12x15 product plus a 14-bit offset.
  localparam int unsigned ADDR_FULL_W = 28;

  typedef struct packed {
    func_e       func;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [12:0] run_length;
    logic [31:0] pixel_color;
  } in_t;

  typedef struct packed {
    logic [31:0] read_color;
    logic        range_error;
  } out_t;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [14:0] line_pitch;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
  } cfg_t;

  typedef struct packed {
    func_e                  func;
    logic                   err;
    logic [ADDR_FULL_W-1:0] addr;
    logic                   nib;
    logic [12:0]            count;
    logic [31:0]            color;
  } cmd_t;

  function automatic logic [15:0] pack565(input logic [31:0] c);
    pack565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

  function automatic logic [31:0] unpack565(input logic [15:0] w);
    unpack565 = {8'd0, w[15:11], 3'd0, w[10:5], 2'd0, w[4:0], 3'd0};
  endfunction

endpackage

@@ design/fbpa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4194304
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fbpa_front.sv @@
// Front end: takes request beats, checks bounds and computes the start byte address.
// Depends on fbpa_pkg.
module fbpa_front import fbpa_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic push_i,
  input  in_t  in_i,
  output logic full_o,
  output logic cmd_push_o,
  output cmd_t cmd_o,
  input  logic cmd_full_i
);

  localparam logic [13:0] MaxDim = 14'(MAX_DIM);

  in_t         st_q;
  logic        st_valid_q, st_valid_d;
  logic        accept;
  logic [13:0] wb, hb, xoff, xend;
  logic [26:0] base;

  assign cmd_push_o = st_valid_q && !cmd_full_i;
  assign full_o     = st_valid_q && cmd_full_i;
  assign accept     = push_i && !full_o;

  always_comb begin
    st_valid_d = st_valid_q;
    if (accept) begin
      st_valid_d = 1'b1;
    end else if (cmd_push_o) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= in_i;
    end
  end

  always_comb begin
    wb   = ({1'b0, cfg_i.frame_width} < MaxDim) ? {1'b0, cfg_i.frame_width} : MaxDim;
    hb   = ({1'b0, cfg_i.frame_height} < MaxDim) ? {1'b0, cfg_i.frame_height} : MaxDim;
    xend = 14'(st_q.pos_x) + 14'(st_q.run_length);
    case (cfg_i.pixel_format)
      FMT_4BPP:  xoff = 14'(st_q.pos_x >> 1);
      FMT_8BPP:  xoff = 14'(st_q.pos_x);
      FMT_16BPP: xoff = {1'b0, st_q.pos_x, 1'b0};
      FMT_24BPP: xoff = 14'(st_q.pos_x) + {1'b0, st_q.pos_x, 1'b0};
      default:   xoff = {st_q.pos_x, 2'b00};
    endcase
    base = 27'(st_q.pos_y) * 27'(cfg_i.line_pitch);

    cmd_o.func  = st_q.func;
    cmd_o.addr  = ADDR_FULL_W'(base) + ADDR_FULL_W'(xoff);
    cmd_o.nib   = st_q.pos_x[0];
    cmd_o.color = st_q.pixel_color;
    if (st_q.func == FUNC_FILL) begin
      cmd_o.err   = (14'(st_q.pos_y) >= hb) || (xend > wb);
      cmd_o.count = st_q.run_length;
    end else begin
      cmd_o.err   = (14'(st_q.pos_x) >= wb) || (14'(st_q.pos_y) >= hb);
      cmd_o.count = 13'd1;
    end
  end

endmodule

@@ design/fbpa_cmd_fifo.sv @@
// Short command queue between the front end and the memory sequencer.
// Depends on fbpa_pkg.
module fbpa_cmd_fifo import fbpa_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/fbpa_back.sv @@
// Back end: walks a command byte by byte over the frame RAM and forms the result.
// Depends on fbpa_pkg and fbpa_ram.
module fbpa_back import fbpa_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 4194304
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic empty_o,
  output out_t out_o,
  input  logic pop_i,
  output logic ram_we_o,
  output logic ram_re_o
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_MOD  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  cmd_t          cur_q, cur_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          nib_q, nib_d;
  logic [12:0]   cnt_q, cnt_d;
  logic [1:0]    bidx_q, bidx_d;
  logic [31:0]   acc_q, acc_d;
  out_t          res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic          we, re;
  logic [7:0]    wdata, rdata;
  logic          nib_mode, need_rd, advance, last_byte;
  logic [1:0]    last_b;
  logic [31:0]   wv;
  logic [7:0]    wbyte, cbyte;
  logic [3:0]    c4;

  fbpa_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign ram_we_o = we;
  assign ram_re_o = re;
  assign empty_o  = !res_valid_q;
  assign out_o    = res_q;

  always_comb begin
    nib_mode = (cfg_i.pixel_format == FMT_4BPP);
    case (cfg_i.pixel_format)
      FMT_8BPP:  last_b = 2'd0;
      FMT_16BPP: last_b = 2'd1;
      FMT_24BPP: last_b = 2'd2;
      default:   last_b = 2'd3;
    endcase
    wv        = (cfg_i.pixel_format == FMT_16BPP) ? {16'd0, pack565(cur_q.color)}
                                                  : cur_q.color;
    wbyte     = 8'(wv >> {bidx_q, 3'b000});
    cbyte     = 8'(cur_q.color >> {bidx_q, 3'b000});
    c4        = cur_q.color[3:0];
    need_rd   = nib_mode || (cur_q.func == FUNC_XOR) || (cur_q.func == FUNC_READ);
    last_byte = nib_mode || (bidx_q == last_b);
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    addr_d      = addr_q;
    nib_d       = nib_q;
    cnt_d       = cnt_q;
    bidx_d      = bidx_q;
    acc_d       = acc_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop_i;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    wdata       = wbyte;
    advance     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          addr_d    = cmd_i.addr[AW-1:0];
          nib_d     = cmd_i.nib;
          cnt_d     = cmd_i.count;
          bidx_d    = 2'd0;
          acc_d     = '0;
          state_d   = (cmd_i.err || cmd_i.count == '0) ? S_DONE : S_STEP;
        end
      end
      S_STEP: begin
        if (need_rd) begin
          re      = 1'b1;
          state_d = S_MOD;
        end else begin
          we      = 1'b1;
          advance = 1'b1;
        end
      end
      S_MOD: begin
        advance = 1'b1;
        if (cur_q.func == FUNC_READ) begin
          if (nib_mode) begin
            acc_d = {28'd0, nib_q ? rdata[3:0] : rdata[7:4]};
          end else begin
            acc_d = acc_q | (32'(rdata) << {bidx_q, 3'b000});
          end
        end else begin
          we = 1'b1;
          if (nib_mode) begin
            if (cur_q.func == FUNC_XOR) begin
              wdata = rdata ^ (nib_q ? {4'd0, c4} : {c4, 4'd0});
            end else begin
              wdata = nib_q ? {rdata[7:4], c4} : {c4, rdata[3:0]};
            end
          end else begin
            wdata = rdata ^ cbyte;
          end
        end
      end
      S_DONE: begin
        if (!res_valid_q || pop_i) begin
          res_valid_d       = 1'b1;
          res_d.range_error = cur_q.err;
          if (cur_q.err || cur_q.func != FUNC_READ) begin
            res_d.read_color = '0;
          end else if (cfg_i.pixel_format == FMT_16BPP) begin
            res_d.read_color = unpack565(acc_q[15:0]);
          end else begin
            res_d.read_color = acc_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Step to the next byte or nibble; a 4-bit pixel moves the address every second pixel.
    if (advance) begin
      state_d = S_STEP;
      if (nib_mode) begin
        nib_d = !nib_q;
        if (nib_q) begin
          addr_d = addr_q + 1'b1;
        end
      end else begin
        addr_d = addr_q + 1'b1;
        bidx_d = last_byte ? 2'd0 : bidx_q + 1'b1;
      end
      if (last_byte) begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 13'd1) begin
          state_d = S_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    addr_q <= addr_d;
    nib_q  <= nib_d;
    cnt_q  <= cnt_d;
    bidx_q <= bidx_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

endmodule

@@ design/framebuffer_pixel_access_engine.sv @@
// Top level of the framebuffer pixel access engine: configuration registers and wiring.
// Depends on fbpa_pkg, fbpa_front, fbpa_cmd_fifo and fbpa_back.

// Requests enter through a one-beat front stage that checks bounds and computes the
// start address, then wait in a two-entry command queue for the memory sequencer, which
// touches the byte-wide frame RAM one byte at a time. A byte that must be read first
// (reads, XORs and every 4-bit pixel) is read in S_STEP and then modified or captured
// in S_MOD, a plain write is done in S_STEP alone; a fill run walks every byte of each
// pixel (every nibble in 4-bit mode). The frame store needs no clearing pass and comes
// out of reset ready. FRAME_BYTES must be a power of two.
module framebuffer_pixel_access_engine import fbpa_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 4194304,
  parameter int unsigned MAX_DIM     = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  in_t                  in_i,
  output logic                 empty,
  input  logic                 pop,
  output out_t                 out_o
);

  localparam int unsigned QueueDepth = 2;

  cfg_t cfg_q;
  logic cmd_push, cmd_full, cmd_pop, cmd_valid, ram_we, ram_re;
  cmd_t cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format <= FMT_32BPP;
      cfg_q.line_pitch   <= 15'd4096;
      cfg_q.frame_width  <= 13'd1024;
      cfg_q.frame_height <= 13'd768;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data_i[2:0];
        REG_LINE_PITCH:   cfg_q.line_pitch   <= cfg_data_i[14:0];
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[12:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  fbpa_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .in_i       (in_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  fbpa_cmd_fifo #(.DEPTH(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .valid_o (cmd_valid)
  );

  fbpa_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .out_o       (out_o),
    .pop_i       (pop),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re)
  );

  // An erring beat never carries a color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.range_error) |-> (out_o.read_color == '0))
    else $error("range error result with nonzero color");

  // The sequencer never reads and writes the frame RAM in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> !ram_re)
    else $error("frame RAM read and write collide");

  // The front end never pushes into a full command queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !cmd_full)
    else $error("command queue overflow");

  // A command is only taken from a queue that holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("command queue underflow");

endmodule
